FILE: hw/rtl/bovl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bovl_pkg
// Types, codes and helpers shared by the bounded ordered value list.
// ----------------------------------------------------------------------------
package bovl_pkg;

  localparam int DEPTH       = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W       = ((CNT_W > 8) ? CNT_W : 8) + 2;

  typedef logic [VALUE_WIDTH-1:0]   entry_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [AW-1:0]            addr_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_APPEND = 3'd1,
    OP_RMVAL  = 3'd2,
    OP_RMLAST = 3'd3,
    OP_RESIZE = 3'd4,
    OP_READ   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2,
    STAT_SAT  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RD_ISSUE,
    S_RD_EMIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    in_ready;
    logic    exec_simple;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_idx;
    logic    rd_idx1;
    logic    wr_shift;
    logic    dec_count;
    logic    set_status;
    status_t status;
    logic    emit_fin;
    logic    emit_entry;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       in_valid;
    logic       idx_lt_count;
    logic       idx1_lt_count;
    logic       match;
    logic       count_zero;
    logic       last_entry;
    logic       out_free;
  } sts_t;

  function automatic entry_t to_entry(logic [31:0] v);
    return entry_t'(v);
  endfunction

  function automatic logic [31:0] to_data(entry_t e);
    logic signed [VALUE_WIDTH-1:0] s;
    s = e;
    return 32'(s);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bovl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bovl_in_if / bovl_out_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface bovl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] value;
  logic signed [7:0]  amount;

  modport source (output valid, output operation, output value, output amount,
                  input ready);
  modport sink   (input valid, input operation, input value, input amount,
                  output ready);
endinterface

interface bovl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic               item_valid;
  logic               last;
  logic [5:0]         count_now;
  logic [5:0]         capacity_now;

  modport source (output valid, output status, output data, output item_valid,
                  output last, output count_now, output capacity_now,
                  input ready);
  modport sink   (input valid, input status, input data, input item_valid,
                  input last, input count_now, input capacity_now,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bovl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bovl_ctrl
// Sequencer for the list operations: search, compaction and read out walk
// the entry memory one address at a time.
// ----------------------------------------------------------------------------
module bovl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bovl_pkg::sts_t  sts,
  output bovl_pkg::cmd_t       cmd
);

  bovl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bovl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.status = bovl_pkg::STAT_OK;
    state_nxt = state_r;
    case (state_r)
      bovl_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_nxt = bovl_pkg::S_EXEC;
        end
      end
      bovl_pkg::S_EXEC: begin
        case (sts.op)
          bovl_pkg::OP_RMVAL: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = bovl_pkg::S_SRCH_RD;
          end
          bovl_pkg::OP_READ: begin
            if (sts.count_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = bovl_pkg::STAT_NONE;
              state_nxt      = bovl_pkg::S_FIN;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = bovl_pkg::S_RD_ISSUE;
            end
          end
          default: begin
            cmd.exec_simple = 1'b1;
            state_nxt       = bovl_pkg::S_FIN;
          end
        endcase
      end
      bovl_pkg::S_SRCH_RD: begin
        if (sts.idx_lt_count) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = bovl_pkg::S_SRCH_CMP;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = bovl_pkg::STAT_NONE;
          state_nxt      = bovl_pkg::S_FIN;
        end
      end
      bovl_pkg::S_SRCH_CMP: begin
        if (sts.match) begin
          state_nxt = bovl_pkg::S_SH_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = bovl_pkg::S_SRCH_RD;
        end
      end
      bovl_pkg::S_SH_RD: begin
        if (sts.idx1_lt_count) begin
          cmd.rd_idx1 = 1'b1;
          state_nxt   = bovl_pkg::S_SH_WR;
        end else begin
          cmd.dec_count  = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = bovl_pkg::STAT_OK;
          state_nxt      = bovl_pkg::S_FIN;
        end
      end
      bovl_pkg::S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = bovl_pkg::S_SH_RD;
      end
      bovl_pkg::S_RD_ISSUE: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = bovl_pkg::S_RD_EMIT;
      end
      bovl_pkg::S_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_entry = 1'b1;
          cmd.idx_inc    = 1'b1;
          state_nxt      = sts.last_entry ? bovl_pkg::S_IDLE : bovl_pkg::S_RD_ISSUE;
        end
      end
      bovl_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.emit_fin = 1'b1;
          state_nxt    = bovl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bovl_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bovl_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bovl_dp
// Entry memory, count and capacity registers, walk index and result register.
// ----------------------------------------------------------------------------
module bovl_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bovl_pkg::cmd_t  cmd,
  output bovl_pkg::sts_t       sts,
  bovl_in_if.sink              in_ch,
  bovl_out_if.source           out_ch
);

  bovl_pkg::entry_t mem [bovl_pkg::DEPTH];
  bovl_pkg::entry_t rdata_r;

  logic [2:0]       op_r;
  bovl_pkg::entry_t val_r;
  logic [7:0]       amt_r;

  bovl_pkg::cnt_t    count_r, count_nxt;
  bovl_pkg::cnt_t    cap_r, cap_nxt;
  bovl_pkg::cnt_t    idx_r, idx_nxt;
  bovl_pkg::status_t status_r, status_nxt;
  bovl_pkg::cnt_t    idx1;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        o_status_r;
  logic [31:0]       o_data_r;
  logic              o_item_r;
  logic              o_last_r;
  logic [5:0]        o_count_r;
  logic [5:0]        o_cap_r;

  bovl_pkg::sum_t    want;
  bovl_pkg::cnt_t    sat_cap;
  logic              sat_flag;

  logic              accept;
  logic              we;
  bovl_pkg::addr_t   waddr;
  bovl_pkg::entry_t  wdata;
  logic              re;
  bovl_pkg::addr_t   raddr;

  assign accept = in_ch.valid && cmd.in_ready;
  assign idx1   = idx_r + 1'b1;

  always_comb begin
    if (op_r == bovl_pkg::OP_RESIZE) begin
      want = bovl_pkg::sum_t'($signed(amt_r)) + bovl_pkg::sum_t'({1'b0, cap_r});
    end else begin
      want = bovl_pkg::sum_t'($signed(amt_r));
    end
    if (want < 0) begin
      sat_cap  = '0;
      sat_flag = 1'b1;
    end else if (want > bovl_pkg::sum_t'(bovl_pkg::DEPTH)) begin
      sat_cap  = bovl_pkg::cnt_t'(bovl_pkg::DEPTH);
      sat_flag = 1'b1;
    end else begin
      sat_cap  = bovl_pkg::cnt_t'(want);
      sat_flag = 1'b0;
    end
  end

  always_comb begin
    count_nxt  = count_r;
    cap_nxt    = cap_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    we         = 1'b0;
    waddr      = idx_r[bovl_pkg::AW-1:0];
    wdata      = rdata_r;
    if (cmd.exec_simple) begin
      status_nxt = bovl_pkg::STAT_OK;
      case (op_r)
        bovl_pkg::OP_INIT: begin
          count_nxt  = '0;
          cap_nxt    = sat_cap;
          status_nxt = sat_flag ? bovl_pkg::STAT_SAT : bovl_pkg::STAT_OK;
        end
        bovl_pkg::OP_APPEND: begin
          if (count_r < cap_r && count_r < bovl_pkg::cnt_t'(bovl_pkg::DEPTH)) begin
            we        = 1'b1;
            waddr     = count_r[bovl_pkg::AW-1:0];
            wdata     = val_r;
            count_nxt = count_r + 1'b1;
          end else begin
            status_nxt = bovl_pkg::STAT_FULL;
          end
        end
        bovl_pkg::OP_RMLAST: begin
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end else begin
            status_nxt = bovl_pkg::STAT_NONE;
          end
        end
        bovl_pkg::OP_RESIZE: begin
          cap_nxt    = sat_cap;
          status_nxt = sat_flag ? bovl_pkg::STAT_SAT : bovl_pkg::STAT_OK;
          if (count_r > sat_cap) begin
            count_nxt = sat_cap;
          end
        end
        default: begin
          status_nxt = bovl_pkg::STAT_OK;
        end
      endcase
    end
    if (cmd.wr_shift) begin
      we    = 1'b1;
      waddr = idx_r[bovl_pkg::AW-1:0];
      wdata = rdata_r;
    end
    if (cmd.dec_count) begin
      count_nxt = count_r - 1'b1;
    end
    if (cmd.set_status) begin
      status_nxt = cmd.status;
    end
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx1;
    end
  end

  assign re    = cmd.rd_idx || cmd.rd_idx1;
  assign raddr = cmd.rd_idx1 ? idx1[bovl_pkg::AW-1:0] : idx_r[bovl_pkg::AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= '0;
    end else begin
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    if (accept) begin
      op_r  <= in_ch.operation;
      val_r <= bovl_pkg::to_entry(in_ch.value);
      amt_r <= in_ch.amount;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_fin || cmd.emit_entry) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_fin) begin
      o_status_r <= status_r;
      o_data_r   <= '0;
      o_item_r   <= 1'b0;
      o_last_r   <= 1'b1;
      o_count_r  <= 6'(count_r);
      o_cap_r    <= 6'(cap_r);
    end else if (cmd.emit_entry) begin
      o_status_r <= bovl_pkg::STAT_OK;
      o_data_r   <= bovl_pkg::to_data(rdata_r);
      o_item_r   <= 1'b1;
      o_last_r   <= (idx1 == count_r);
      o_count_r  <= 6'(count_r);
      o_cap_r    <= 6'(cap_r);
    end
  end

  assign in_ch.ready         = cmd.in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.data         = o_data_r;
  assign out_ch.item_valid   = o_item_r;
  assign out_ch.last         = o_last_r;
  assign out_ch.count_now    = o_count_r;
  assign out_ch.capacity_now = o_cap_r;

  assign sts.op            = op_r;
  assign sts.in_valid      = in_ch.valid;
  assign sts.idx_lt_count  = (idx_r < count_r);
  assign sts.idx1_lt_count = (idx1 < count_r);
  assign sts.match         = (rdata_r == val_r);
  assign sts.count_zero    = (count_r == '0);
  assign sts.last_entry    = (idx1 == count_r);
  assign sts.out_free      = !out_valid_r || out_ch.ready;

endmodule
`default_nettype wire

FILE: hw/rtl/bounded_ordered_value_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_ordered_value_list
// Ordered list of signed values with run-time capacity: init, append,
// remove by value, remove last, resize and read out.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  in_ch    | in  | operation[2:0], value[31:0] s, amount[7:0] s
//  out_ch   | out | status[1:0], data[31:0] s, item_valid, last,
//           |     | count_now[5:0], capacity_now[5:0]
//
//  Init, append, remove last, resize: executed in S_EXEC, result from S_FIN.
//  Remove by value: a read and a compare state per entry searched, then a
//  read and a write state per entry moved up; one entry memory access per
//  cycle with registered read. Read out: one result per entry.
//  Reset clears count and capacity; entry memory is not cleared.
//  A new item is taken while the last result waits in the output register.
// ----------------------------------------------------------------------------
module bounded_ordered_value_list (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bovl_in_if.sink     in_ch,
  bovl_out_if.source  out_ch
);

  bovl_pkg::cmd_t cmd;
  bovl_pkg::sts_t sts;

  bovl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  bovl_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives operation items into bounded_ordered_value_list and checks every
// result item, field by field, against a list model kept in step with the
// block. Directed corner cases come first, then a fill under a long output
// stall, then random traffic. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bovl_pkg::*;

  localparam logic [2:0] OP_SPARE6  = 3'd6;
  localparam logic [2:0] OP_SPARE7  = 3'd7;
  localparam int CYCLE_LIMIT        = 2_000_000;
  localparam int SETTLE_CYCLES      = 4 * DEPTH + 16;

  typedef struct {
    status_t     status;
    logic [31:0] data;
    logic        item_valid;
    logic        last;
    logic [5:0]  count_now;
    logic [5:0]  capacity_now;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bovl_in_if  in_ch ();
  bovl_out_if out_ch ();

  bounded_ordered_value_list uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  entry_t       list_vals [DEPTH];
  int           list_len = 0;
  int           list_cap = 0;
  list_result_t list_results [$];
  int           errors   = 0;
  int           cycles   = 0;
  int           hold_len = 0;
  bit           steady   = 1'b0;

  always #10ns clk = ~clk;

  function automatic bit clamp_capacity(int want);
    if (want < 0) begin
      list_cap = 0;
      return 1'b1;
    end
    if (want > DEPTH) begin
      list_cap = DEPTH;
      return 1'b1;
    end
    list_cap = want;
    return 1'b0;
  endfunction

  function automatic void push_result(status_t st, logic [31:0] data, logic vld, logic lst);
    list_result_t r;
    r.status       = st;
    r.data         = data;
    r.item_valid   = vld;
    r.last         = lst;
    r.count_now    = 6'(list_len);
    r.capacity_now = 6'(list_cap);
    list_results.push_back(r);
  endfunction

  function automatic void apply_list_op(logic [2:0] op, logic [31:0] value,
                                        logic signed [7:0] amount);
    entry_t  key;
    status_t st;
    int      hit;
    key = entry_t'(value);
    st  = STAT_OK;
    case (op)
      OP_INIT: begin
        list_len = 0;
        if (clamp_capacity(int'(amount))) st = STAT_SAT;
      end
      OP_APPEND: begin
        if (list_len < list_cap) begin
          list_vals[list_len] = key;
          list_len++;
        end else begin
          st = STAT_FULL;
        end
      end
      OP_RMVAL: begin
        hit = -1;
        for (int i = 0; i < list_len; i++)
          if (hit < 0 && list_vals[i] == key) hit = i;
        if (hit < 0) begin
          st = STAT_NONE;
        end else begin
          for (int i = hit; i < list_len - 1; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
        end
      end
      OP_RMLAST: begin
        if (list_len > 0) list_len--;
        else st = STAT_NONE;
      end
      OP_RESIZE: begin
        if (clamp_capacity(list_cap + int'(amount))) st = STAT_SAT;
        if (list_len > list_cap) list_len = list_cap;
      end
      OP_READ: begin
        if (list_len == 0) begin
          push_result(STAT_NONE, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            push_result(STAT_OK, 32'(signed'(list_vals[i])), 1'b1, i == list_len - 1);
        end
      end
      default: ;
    endcase
    if (op != OP_READ) push_result(st, '0, 1'b0, 1'b1);
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'($urandom_range(0, 7)) - 32'd4;
    if (r < 48) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [7:0] rand_amount();
    int a;
    a = $urandom_range(0, 128);
    return 8'(a - 64);
  endfunction

  task automatic send_item(logic [2:0] op, logic [31:0] value, logic signed [7:0] amount);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= value;
    in_ch.amount    <= amount;
    do @(posedge clk); while (!in_ch.ready);
    apply_list_op(op, value, amount);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (list_results.size() == 0) begin
        $error("unexpected result item: status %0d, data %0h", out_ch.status, out_ch.data);
        errors++;
      end else begin
        want = list_results.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("data", want.data, out_ch.data);
        check_field("item_valid", want.item_valid, out_ch.item_valid);
        check_field("last", want.last, out_ch.last);
        check_field("count_now", want.count_now, out_ch.count_now);
        check_field("capacity_now", want.capacity_now, out_ch.capacity_now);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_empty_list();
    send_item(OP_READ, $urandom, rand_amount());
    send_item(OP_RMLAST, $urandom, rand_amount());
    send_item(OP_RMVAL, 32'd0, 8'sd0);
  endtask

  task automatic test_init_saturation();
    send_item(OP_INIT, 32'd0, -8'sd64);
    send_item(OP_APPEND, 32'd1, 8'sd0);
    send_item(OP_INIT, 32'd0, 8'sd64);
  endtask

  task automatic test_append_full();
    send_item(OP_INIT, 32'd0, 8'sd3);
    send_item(OP_APPEND, 32'h7FFF_FFFF, 8'sd0);
    send_item(OP_APPEND, 32'h8000_0000, 8'sd0);
    send_item(OP_APPEND, 32'h8000_0000, 8'sd0);
    send_item(OP_APPEND, 32'd5, 8'sd0);
    send_item(OP_READ, 32'd0, 8'sd0);
  endtask

  task automatic test_remove_value();
    send_item(OP_RMVAL, 32'h8000_0000, 8'sd0);
    send_item(OP_RMVAL, 32'd12345, 8'sd0);
  endtask

  task automatic test_resize();
    send_item(OP_RESIZE, 32'd0, 8'sd64);
    send_item(OP_RESIZE, 32'd0, -8'sd64);
    send_item(OP_INIT, 32'd0, 8'sd4);
    send_item(OP_APPEND, 32'hFFFF_FFFF, 8'sd0);
    send_item(OP_APPEND, 32'd0, 8'sd0);
    send_item(OP_APPEND, 32'd1, 8'sd0);
    send_item(OP_APPEND, 32'hFFFF_FFFF, 8'sd0);
    send_item(OP_RESIZE, 32'd0, -8'sd2);
    send_item(OP_RMLAST, 32'd0, 8'sd0);
    send_item(OP_READ, 32'd0, 8'sd0);
  endtask

  task automatic test_unknown_op();
    send_item(OP_SPARE6, $urandom, rand_amount());
    send_item(OP_SPARE7, $urandom, rand_amount());
  endtask

  task automatic test_backpressure();
    hold_len = 400;
    send_item(OP_INIT, $urandom, 8'(DEPTH));
    for (int i = 0; i < DEPTH; i++) send_item(OP_APPEND, pick_value(), rand_amount());
    send_item(OP_APPEND, pick_value(), rand_amount());
    send_item(OP_READ, $urandom, rand_amount());
    send_item(OP_RMVAL, 32'(list_vals[0]), rand_amount());
    send_item(OP_RMVAL, 32'(list_vals[list_len - 1]), rand_amount());
    send_item(OP_RMVAL, $urandom, rand_amount());
    send_item(OP_READ, $urandom, rand_amount());
  endtask

  task automatic test_random(int n);
    int                r;
    logic [31:0]       v;
    logic signed [7:0] a;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (list_cap == 0 && $urandom_range(0, 3) == 0) r = 0;
      v = pick_value();
      a = rand_amount();
      if (r < 4) begin
        if ($urandom_range(0, 3) != 0) a = 8'($urandom_range(1, DEPTH));
        send_item(OP_INIT, v, a);
      end else if (r < 7) begin
        send_item($urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6, v, a);
      end else if (r < 40) begin
        send_item(OP_APPEND, v, a);
      end else if (r < 58) begin
        if (list_len > 0 && $urandom_range(0, 9) < 7)
          v = list_vals[$urandom_range(0, list_len - 1)];
        send_item(OP_RMVAL, v, a);
      end else if (r < 66) begin
        send_item(OP_RMLAST, v, a);
      end else if (r < 76) begin
        if ($urandom_range(0, 4) != 0) a = 8'(int'($urandom_range(0, 16)) - 8);
        send_item(OP_RESIZE, v, a);
      end else begin
        send_item(OP_READ, v, a);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_INIT;
    in_ch.value     <= '0;
    in_ch.amount    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_init_saturation();
    test_append_full();
    test_remove_value();
    test_resize();
    test_unknown_op();
    test_backpressure();
    test_random(420);

    in_ch.valid <= 1'b0;
    while (list_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
